// ===== rtl/btrg_pkg.sv =====
package btrg_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} btrg_state_t;

	localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam int         ROM_COLS   = 5;

	// one glyph column, bit 0 is the top row; columns past the rom are blank
	function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] col);
		logic [39:0] g;
		logic [7:0]  res;
		case (code)
			8'h30: g = 40'h3E_45_49_51_3E;
			8'h31: g = 40'h00_40_7F_42_00;
			8'h32: g = 40'h46_49_51_61_42;
			8'h33: g = 40'h31_4B_45_41_21;
			8'h34: g = 40'h10_7F_12_14_18;
			8'h35: g = 40'h39_45_45_45_27;
			8'h36: g = 40'h30_49_49_4A_3C;
			8'h37: g = 40'h03_05_09_71_01;
			8'h38: g = 40'h36_49_49_49_36;
			8'h39: g = 40'h1E_29_49_49_06;
			8'h45: g = 40'h41_49_49_49_7F;
			8'h46: g = 40'h01_09_09_09_7F;
			8'h4B: g = 40'h41_22_14_08_7F;
			8'h4C: g = 40'h40_40_40_40_7F;
			8'h4D: g = 40'h7F_02_0C_02_7F;
			8'h4F: g = 40'h3E_41_41_41_3E;
			8'h52: g = 40'h46_29_19_09_7F;
			8'h53: g = 40'h31_49_49_49_46;
			8'h57: g = 40'h7F_20_18_20_7F;
			8'h2E: g = 40'h00_00_60_60_00;
			default: g = 40'h0;
		endcase
		if (int'(col) < ROM_COLS) res = g[{col, 3'b000} +: 8];
		else res = 8'h00;
		return res;
	endfunction

endpackage

// ===== rtl/bitmap_text_rect_generator_core.sv =====
// channel  dir  tdata (low bit up)                                       tuser / tlast
// s_*      in   char_code, start_x, start_y, scale, color (52 of 56 bits) first_of_text
// m_*      out  rect_x, rect_y, rect_w, rect_h, fill_color (44 of 48)      last_of_char
// cfg_*    in   write port: 0 screen_width, 1 screen_height
//
// a character goes ST_IDLE, ST_WALK (one step per dot), ST_FLUSH; a space skips ST_WALK;
// the glyph walk visits one dot per cycle, unless a square stalls on m_tready, through one
// x/y position adder pair and clipper; squares are held one deep so the final one can be marked
// arst_n resets control state, cursor, held scale and screen registers; walk counters and payload are not reset
module bitmap_text_rect_generator_core import btrg_pkg::*; #(
	parameter int GLYPH_COLUMNS = 5,
	parameter int GLYPH_ROWS    = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // char_code, start_x, start_y, scale, color
	input  logic        s_tuser,   // first_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // rect_x, rect_y, rect_w, rect_h, fill_color
	output logic        m_tlast,   // last_of_char
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [9:0]  cfg_data
);

	localparam int COL_W = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
	localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

	btrg_state_t state_q, state_nxt;

	logic [9:0]        screen_w_q, screen_h_q;
	logic signed [15:0] cursor_q;
	logic [11:0]       y_q;
	logic [3:0]        scale_q;
	logic [15:0]       color_q;
	logic [7:0]        code_q;
	logic              space_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic signed [16:0] px_q;
	logic signed [13:0] py_q;

	logic        pend_valid_q;
	logic [9:0]  pend_x_q, pend_y_q;
	logic [3:0]  pend_w_q, pend_h_q;

	logic        out_valid_q, out_last_q;
	logic [9:0]  out_x_q, out_y_q;
	logic [3:0]  out_w_q, out_h_q;
	logic [15:0] out_color_q;

	logic        accept, out_free, bit_set, hit, stall, step, last_bit, push, flush_done;
	logic [15:0] cur_start;
	logic [7:0]  col_bits;
	logic signed [17:0] x18, xe18, cx18, rx18, w18;
	logic signed [17:0] y18, ye18, cy18, ry18, h18;
	logic signed [17:0] scale18, sw18, sh18, sum18;
	logic [6:0]  adv;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// clipper: one square at (px, py)
	assign scale18 = $signed({14'b0, scale_q});
	assign sw18    = $signed({8'b0, screen_w_q});
	assign sh18    = $signed({8'b0, screen_h_q});
	assign x18  = {px_q[16], px_q};
	assign xe18 = x18 + scale18;
	assign cx18 = x18[17] ? 18'sd0 : x18;
	assign rx18 = (xe18 > sw18) ? sw18 : xe18;
	assign w18  = rx18 - cx18;
	assign y18  = {{4{py_q[13]}}, py_q};
	assign ye18 = y18 + scale18;
	assign cy18 = y18[17] ? 18'sd0 : y18;
	assign ry18 = (ye18 > sh18) ? sh18 : ye18;
	assign h18  = ry18 - cy18;

	assign col_bits = glyph_column(code_q, 3'(col_q));
	assign bit_set  = col_bits[row_q];
	assign hit      = bit_set && !w18[17] && (w18 != 18'sd0) && !h18[17] && (h18 != 18'sd0);
	assign last_bit = (col_q == COL_W'(GLYPH_COLUMNS - 1)) && (row_q == ROW_W'(GLYPH_ROWS - 1));

	assign cur_start = s_tuser ? {{4{s_tdata[19]}}, s_tdata[19:8]} : cursor_q;

	// cursor advance, saturating; the step is never negative
	assign adv   = space_q ? {1'b0, scale_q, 2'b00} : ({1'b0, scale_q, 2'b00} + {2'b0, scale_q, 1'b0});
	assign sum18 = {{2{cursor_q[15]}}, cursor_q} + $signed({11'b0, adv});

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = (s_tdata[7:0] == CHAR_SPACE) ? ST_FLUSH : ST_WALK;
			end
			ST_WALK: begin
				if (step && last_bit) state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (flush_done) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		stall      = 1'b0;
		step       = 1'b0;
		push       = 1'b0;
		flush_done = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_WALK: begin
				stall = hit && pend_valid_q && !out_free;
				step  = !stall;
				push  = hit && pend_valid_q && out_free;
			end
			ST_FLUSH: begin
				flush_done = !pend_valid_q || out_free;
				push       = pend_valid_q && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			screen_w_q   <= 10'd284;
			screen_h_q   <= 10'd76;
			cursor_q     <= 16'sd0;
			y_q          <= 12'd0;
			scale_q      <= 4'd1;
			color_q      <= 16'd0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_idx)
					REG_SCREEN_WIDTH:  screen_w_q <= cfg_data;
					REG_SCREEN_HEIGHT: screen_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				cursor_q <= cur_start;
				if (s_tuser) begin
					y_q     <= s_tdata[31:20];
					scale_q <= s_tdata[35:32];
					color_q <= s_tdata[51:36];
				end
			end
			if (state_q == ST_WALK && step && hit) pend_valid_q <= 1'b1;
			else if (state_q == ST_FLUSH && flush_done) pend_valid_q <= 1'b0;
			if (state_q == ST_FLUSH && flush_done)
				cursor_q <= (sum18 > 18'sd32767) ? 16'sd32767 : sum18[15:0];
			if (push) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// walk counters, positions and square payload
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q  <= s_tdata[7:0];
			space_q <= (s_tdata[7:0] == CHAR_SPACE);
			col_q   <= '0;
			row_q   <= '0;
			px_q    <= {cur_start[15], cur_start};
			py_q    <= s_tuser ? {{2{s_tdata[31]}}, s_tdata[31:20]} : {{2{y_q[11]}}, y_q};
		end else if (state_q == ST_WALK && step) begin
			if (row_q == ROW_W'(GLYPH_ROWS - 1)) begin
				row_q <= '0;
				col_q <= col_q + 1'b1;
				px_q  <= px_q + $signed({13'b0, scale_q});
				py_q  <= {{2{y_q[11]}}, y_q};
			end else begin
				row_q <= row_q + 1'b1;
				py_q  <= py_q + $signed({10'b0, scale_q});
			end
		end
		if (state_q == ST_WALK && step && hit) begin
			pend_x_q <= cx18[9:0];
			pend_y_q <= cy18[9:0];
			pend_w_q <= w18[3:0];
			pend_h_q <= h18[3:0];
		end
		if (push) begin
			out_x_q     <= pend_x_q;
			out_y_q     <= pend_y_q;
			out_w_q     <= pend_w_q;
			out_h_q     <= pend_h_q;
			out_color_q <= color_q;
			out_last_q  <= (state_q == ST_FLUSH);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_color_q, out_h_q, out_w_q, out_y_q, out_x_q};
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_valid_q)
		else $error("square left pending while idle");

	a_flush_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && push) |=> (m_tvalid && m_tlast))
		else $error("final square not marked");

	a_walk_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && push) |=> (m_tvalid && !m_tlast))
		else $error("inner square marked last");

	a_zero_scale_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && scale_q == 4'd0) |-> !hit)
		else $error("empty square accepted");

	a_flush_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && flush_done) |=> s_tready)
		else $error("not ready after character");
`endif

endmodule

// ===== tb/btrg_checker.sv =====
`timescale 1ns / 100ps

module btrg_checker import btrg_pkg::*; #(
	parameter int GLYPH_COLUMNS = 5,
	parameter int GLYPH_ROWS    = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,   // char_code, start_x, start_y, scale, color
	input  logic        s_tuser,   // first_of_text
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // rect_x, rect_y, rect_w, rect_h, fill_color
	input  logic        m_tlast,   // last_of_char
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [9:0]  cfg_data,
	output int          fail_count,
	output int          rects_waiting,
	output int          rects_seen
);

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [3:0]  w;
		logic [3:0]  h;
		logic [15:0] color;
		logic        last;
	} square_t;

	square_t     pending_squares[$];
	int          cursor_x;
	int          held_y;
	int          held_scale;
	logic [15:0] held_color;
	int          scr_w;
	int          scr_h;

	// dot columns of the font, bit 0 is the top row
	function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
		logic [0:4][7:0] c;
		case (code)
			"0": c = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
			"1": c = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
			"2": c = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			"3": c = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
			"4": c = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
			"5": c = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			"6": c = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
			"7": c = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			"8": c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			"9": c = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
			"E": c = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
			"F": c = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
			"K": c = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
			"L": c = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
			"M": c = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
			"O": c = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
			"R": c = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
			"S": c = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
			"W": c = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
			".": c = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
			default: c = '0;
		endcase
		return (col < 5) ? c[col] : 8'h00;
	endfunction

	function automatic int sat16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	task automatic plot_glyph(input logic [7:0] code, input logic first, input logic [11:0] sx,
			input logic [11:0] sy, input logic [3:0] sc, input logic [15:0] color);
		int      s, x, y, w, h, n, last_idx;
		logic [7:0] bits;
		square_t sq;
		if (first) begin
			cursor_x   = $signed(sx);
			held_y     = $signed(sy);
			held_scale = sc;
			held_color = color;
		end
		s = held_scale;
		if (code == CHAR_SPACE) begin
			cursor_x = sat16(cursor_x + 4 * s);
		end else begin
			n = 0;
			last_idx = 0;
			for (int col = 0; col < GLYPH_COLUMNS; col++) begin
				bits = font_column(code, col);
				for (int row = 0; row < GLYPH_ROWS && row < 8; row++) begin
					if (bits[row]) begin
						x = cursor_x + col * s;
						y = held_y + row * s;
						w = s;
						h = s;
						if (x < 0) begin
							w = w + x;
							x = 0;
						end
						if (y < 0) begin
							h = h + y;
							y = 0;
						end
						if (x + w > scr_w) w = scr_w - x;
						if (y + h > scr_h) h = scr_h - y;
						if (w > 0 && h > 0) begin
							sq.x     = x[9:0];
							sq.y     = y[9:0];
							sq.w     = w[3:0];
							sq.h     = h[3:0];
							sq.color = held_color;
							sq.last  = 1'b0;
							pending_squares.push_back(sq);
							last_idx = pending_squares.size() - 1;
							n++;
						end
					end
				end
			end
			if (n > 0) begin
				sq = pending_squares[last_idx];
				sq.last = 1'b1;
				pending_squares[last_idx] = sq;
			end
			cursor_x = sat16(cursor_x + 6 * s);
		end
	endtask

	task automatic check_square(input logic [47:0] data, input logic last);
		square_t want;
		if (pending_squares.size() == 0) begin
			$error("square with none expected: x %0d y %0d w %0d h %0d", data[9:0],
				data[19:10], data[23:20], data[27:24]);
			fail_count++;
		end else begin
			want = pending_squares.pop_front();
			if (data[9:0] !== want.x) begin
				$error("rect_x: expected %0d, got %0d", want.x, data[9:0]);
				fail_count++;
			end
			if (data[19:10] !== want.y) begin
				$error("rect_y: expected %0d, got %0d", want.y, data[19:10]);
				fail_count++;
			end
			if (data[23:20] !== want.w) begin
				$error("rect_w: expected %0d, got %0d", want.w, data[23:20]);
				fail_count++;
			end
			if (data[27:24] !== want.h) begin
				$error("rect_h: expected %0d, got %0d", want.h, data[27:24]);
				fail_count++;
			end
			if (data[43:28] !== want.color) begin
				$error("fill_color: expected %h, got %h", want.color, data[43:28]);
				fail_count++;
			end
			if (last !== want.last) begin
				$error("last_of_char: expected %0d, got %0d", want.last, last);
				fail_count++;
			end
		end
		rects_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_squares.delete();
			cursor_x      = 0;
			held_y        = 0;
			held_scale    = 1;
			held_color    = '0;
			scr_w         = 284;
			scr_h         = 76;
			fail_count    = 0;
			rects_waiting = 0;
			rects_seen    = 0;
		end else begin
			if (m_tvalid && m_tready) check_square(m_tdata, m_tlast);
			if (cfg_we) begin
				if (cfg_idx == REG_SCREEN_WIDTH) scr_w = cfg_data;
				else scr_h = cfg_data;
			end
			if (s_tvalid && s_tready)
				plot_glyph(s_tdata[7:0], s_tuser, s_tdata[19:8], s_tdata[31:20], s_tdata[35:32],
					s_tdata[51:36]);
			rects_waiting = pending_squares.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import btrg_pkg::*;

	localparam int GLYPH_COLUMNS = 5;
	localparam int GLYPH_ROWS    = 7;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 48;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;   // char_code, start_x, start_y, scale, color
	logic        s_tuser  = 1'b0; // first_of_text
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // rect_x, rect_y, rect_w, rect_h, fill_color
	logic        m_tlast;         // last_of_char
	logic        cfg_we   = 1'b0;
	logic [0:0]  cfg_idx  = REG_SCREEN_WIDTH;
	logic [9:0]  cfg_data = '0;

	int    fail_count;
	int    rects_waiting;
	int    rects_seen;
	int    cycle_cnt  = 0;
	int    chars_sent = 0;
	int    settings   = 1;
	int    stall_left = 0;
	bit    idle_on    = 1'b1;
	int    cur_w      = 284;
	int    cur_h      = 76;
	string glyph_chars = "0123456789EFKLMORSW.";

	bitmap_text_rect_generator_core #(
		.GLYPH_COLUMNS(GLYPH_COLUMNS),
		.GLYPH_ROWS   (GLYPH_ROWS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	btrg_checker #(
		.GLYPH_COLUMNS(GLYPH_COLUMNS),
		.GLYPH_ROWS   (GLYPH_ROWS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.rects_waiting(rects_waiting),
		.rects_seen   (rects_seen)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("== FAIL ==");
			$finish;
		end
	end

	// square sink backpressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_tready = 1'b0;
			stall_left = $urandom_range(0, 7);
		end else begin
			m_tready = 1'b1;
		end
	end

	task automatic send_char(input logic [7:0] code, input logic first, input logic [11:0] sx,
			input logic [11:0] sy, input logic [3:0] sc, input logic [15:0] color);
		s_tdata  = {4'b0000, color, sc, sy, sx, code};
		s_tuser  = first;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		chars_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	// follow-on character, the ignored position fields carry noise
	task automatic send_next(input logic [7:0] code);
		send_char(code, 1'b0, 12'($urandom), 12'($urandom), 4'($urandom), 16'($urandom));
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (rects_waiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_screen(input int w, input int h);
		wait_idle();
		cfg_we   = 1'b1;
		cfg_idx  = REG_SCREEN_WIDTH;
		cfg_data = w[9:0];
		@(negedge clk);
		cfg_idx  = REG_SCREEN_HEIGHT;
		cfg_data = h[9:0];
		@(negedge clk);
		cfg_we   = 1'b0;
		cur_w    = w;
		cur_h    = h;
		settings++;
	endtask

	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
		if (r < 75) return CHAR_SPACE;
		return 8'($urandom);
	endfunction

	task automatic random_text(input int len);
		int sx, sy;
		logic [3:0] sc;
		if ($urandom_range(0, 3) == 0) begin
			sx = $urandom;
			sy = $urandom;
		end else begin
			sx = $urandom_range(0, cur_w + 40) - 30;
			sy = $urandom_range(0, cur_h + 40) - 30;
		end
		sc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'($urandom_range(1, 4));
		send_char(pick_code(), 1'b1, sx[11:0], sy[11:0], sc, 16'($urandom));
		for (int i = 1; i < len; i++) send_next(pick_code());
	endtask

	task automatic random_phase(input int n_chars);
		int sent, len;
		sent = 0;
		while (sent < n_chars) begin
			len = $urandom_range(1, 8);
			random_text(len);
			sent += len;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: whole font at scale 1 on the default screen
		send_char("0", 1'b1, 12'd0, 12'd0, 4'd1, 16'hFFFF);
		for (int i = 0; i < glyph_chars.len(); i++) send_next(glyph_chars[i]);
		send_next(CHAR_SPACE);
		send_next(8'h00);
		send_next(8'hFF);
		// clipping on each edge and fully off screen
		send_char("8", 1'b1, -12'sd3, -12'sd2, 4'd4, 16'h0000);
		send_char("W", 1'b1, 12'd280, 12'd72, 4'd3, 16'h5A5A);
		send_char("M", 1'b1, 12'h7FF, 12'h7FF, 4'd15, 16'hFFFF);
		send_char("E", 1'b1, 12'h800, 12'h800, 4'd15, 16'h1234);
		// zero scale draws nothing and keeps the cursor
		send_char(".", 1'b1, 12'd10, 12'd10, 4'd0, 16'hABCD);
		send_next("8");
		send_char("0", 1'b1, 12'd100, 12'd20, 4'd15, 16'hA5A5);
		send_next("K");

		// cursor runs far past the right edge
		send_char(CHAR_SPACE, 1'b1, 12'h7FF, 12'd0, 4'd15, 16'hC3C3);
		idle_on = 1'b0;
		repeat (8) send_next(CHAR_SPACE);
		idle_on = 1'b1;
		send_next("8");
		send_next(8'h7F);
		send_next("1");
		send_char("O", 1'b1, 12'd10, 12'd10, 4'd2, 16'h0F0F);

		// screen with no rows
		set_screen(284, 0);
		send_char("8", 1'b1, 12'd5, 12'd5, 4'd2, 16'h7777);
		send_next("W");

		set_screen(1023, 1023);
		send_char("8", 1'b1, 12'd1010, 12'd1015, 4'd15, 16'hFFFF);
		random_phase(30);

		set_screen($urandom_range(40, 400), $urandom_range(20, 200));
		random_phase(30);

		set_screen(1, 1);
		send_char("8", 1'b1, 12'd0, 12'd0, 4'd1, 16'h8001);
		random_phase(10);

		// final stretch without idling on either side
		set_screen(284, 76);
		idle_on = 1'b0;
		random_phase(40);

		wait_idle();
		$display("sent %0d characters, checked %0d squares across %0d screen settings",
			chars_sent, rects_seen, settings);
		$display("covered clipping on all edges, zero scale, blank codes and a far-off cursor");
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/btrg_pkg.sv
rtl/bitmap_text_rect_generator_core.sv
tb/btrg_checker.sv
tb/tb_top.sv
